[rtl/core/normalized_edit_distance_similarity_macros.svh]
// assertion helpers for the checker
`ifndef NORMALIZED_EDIT_DISTANCE_SIMILARITY_MACROS_SVH
`define NORMALIZED_EDIT_DISTANCE_SIMILARITY_MACROS_SVH

// property that holds in the same cycle
`define NEDS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define NEDS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/neds_pkg.sv]
// ----------------------------------------------------------------------------
// neds_pkg
// types, constants and the byte normalizer shared by the similarity block
// ----------------------------------------------------------------------------
package neds_pkg;

   localparam int MAX_LEN   = 64;
   localparam int ADDR_W    = $clog2(MAX_LEN);
   localparam int CNT_W     = 7;
   localparam int CHAR_W    = 7;
   localparam int CODE_W    = 8;
   localparam int SIM_W     = 17;
   localparam int FRAC_W    = 16;
   localparam int NUM_W     = CNT_W + FRAC_W;
   localparam int PROD_W    = SIM_W + CNT_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam logic [SIM_W-1:0] THR_RESET = 17'd52429;
   localparam logic [SIM_W-1:0] SIM_ONE   = 17'd65536;

   localparam logic CMD_REF   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_INIT,
      ST_ROW,
      ST_CELL_RD,
      ST_CELL_WR,
      ST_FINISH,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic init_step;
      logic row_start;
      logic cell_read;
      logic cell_write;
      logic finish;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic trigger;
      logic both_nonzero;
      logic col_last;
      logic row_last;
      logic div_done;
      logic out_free;
   } sts_type;

   // zero means the byte is dropped
   function automatic logic [CHAR_W-1:0] normalize_char(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] res;
      res = '0;
      if (code >= 8'h30 && code <= 8'h39) begin
         res = code[CHAR_W-1:0];
      end else if (code >= 8'h61 && code <= 8'h7a) begin
         res = code[CHAR_W-1:0];
      end else if (code >= 8'h41 && code <= 8'h5a) begin
         res = code[CHAR_W-1:0] + 7'h20;
      end
      return res;
   endfunction

endpackage

[rtl/core/neds_ctrl.sv]
// ----------------------------------------------------------------------------
// neds_ctrl
// sequencer: loading, row init, cell sweep, divide and result hand-off
// ----------------------------------------------------------------------------
module neds_ctrl
   import neds_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.trigger) state_in = ST_START;
         end
         ST_START: begin
            state_in = sts.both_nonzero ? ST_INIT : ST_FINISH;
         end
         ST_INIT: begin
            if (sts.col_last) state_in = ST_ROW;
         end
         ST_ROW: begin
            state_in = ST_CELL_RD;
         end
         ST_CELL_RD: begin
            state_in = ST_CELL_WR;
         end
         ST_CELL_WR: begin
            if (!sts.col_last) state_in = ST_CELL_RD;
            else if (sts.row_last) state_in = ST_FINISH;
            else state_in = ST_ROW;
         end
         ST_FINISH: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_START:   cmd.start      = 1'b1;
         ST_INIT:    cmd.init_step  = 1'b1;
         ST_ROW:     cmd.row_start  = 1'b1;
         ST_CELL_RD: cmd.cell_read  = 1'b1;
         ST_CELL_WR: cmd.cell_write = 1'b1;
         ST_FINISH:  cmd.finish     = 1'b1;
         ST_DIV:     cmd.div_step   = !sts.div_done;
         ST_OUT:     cmd.out_load   = sts.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/core/neds_dpath.sv]
// ----------------------------------------------------------------------------
// neds_dpath
// character stores, distance row memory, cell arithmetic, divider, output reg
// ----------------------------------------------------------------------------
module neds_dpath
   import neds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               req_command,
   input  logic [CODE_W-1:0]  req_char_code,
   input  logic               req_last,
   input  logic               csr_wr_en,
   input  logic [SIM_W-1:0]   csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CNT_W-1:0]   rsp_distance,
   output logic [CNT_W-1:0]   rsp_ref_length,
   output logic [CNT_W-1:0]   rsp_query_length,
   output logic [SIM_W-1:0]   rsp_similarity_q16,
   output logic               rsp_is_match,
   output logic               rsp_overflow
);

   logic [CHAR_W-1:0] ref_mem [0:MAX_LEN-1];
   logic [CHAR_W-1:0] qry_mem [0:MAX_LEN-1];
   logic [CNT_W-1:0]  row_mem [0:MAX_LEN];

   logic [SIM_W-1:0]  thr_ff;
   logic [CNT_W-1:0]  ref_cnt_ff, qry_cnt_ff;
   logic              trunc_ff;
   logic [CNT_W-1:0]  i_ff, j_ff, left_ff, diag_ff;
   logic [CHAR_W-1:0] ref_rd_ff, qry_rd_ff;
   logic [CNT_W-1:0]  row_rd_ff;

   logic [CNT_W-1:0]  res_dist_ff, res_ref_ff, res_qry_ff, res_max_ff;
   logic              res_trunc_ff;
   logic [NUM_W-1:0]  num_ff, quo_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic              rsp_valid_ff;

   logic [CHAR_W-1:0] char_n;
   logic              ref_full, qry_full, ref_we, qry_we;
   logic [CNT_W-1:0]  i_m1, j_m1, best, up_p1, left_p1, diag_c, maxlen, dist_n;
   logic              cost, row_we;
   logic [CNT_W-1:0]  row_wdata;
   logic [CNT_W:0]    rem_sh;
   logic              q_bit;
   logic [CNT_W-1:0]  rem_n;

   assign char_n   = normalize_char(req_char_code);
   assign ref_full = (ref_cnt_ff == CNT_W'(MAX_LEN));
   assign qry_full = (qry_cnt_ff == CNT_W'(MAX_LEN));
   assign ref_we   = cmd.load && (char_n != '0) && (req_command == CMD_REF) && !ref_full;
   assign qry_we   = cmd.load && (char_n != '0) && (req_command == CMD_QUERY) && !qry_full;
   assign i_m1     = i_ff - 1'b1;
   assign j_m1     = j_ff - 1'b1;

   // character stores
   always_ff @(posedge clock) begin
      if (ref_we) ref_mem[ref_cnt_ff[ADDR_W-1:0]] <= char_n;
      if (qry_we) qry_mem[qry_cnt_ff[ADDR_W-1:0]] <= char_n;
   end

   always_ff @(posedge clock) begin
      if (cmd.row_start) ref_rd_ff <= ref_mem[i_m1[ADDR_W-1:0]];
      if (cmd.cell_read) qry_rd_ff <= qry_mem[j_m1[ADDR_W-1:0]];
   end

   // distance row
   assign cost      = (ref_rd_ff != qry_rd_ff);
   assign up_p1     = row_rd_ff + 1'b1;
   assign left_p1   = left_ff + 1'b1;
   assign diag_c    = diag_ff + CNT_W'(cost);
   always_comb begin
      best = up_p1;
      if (left_p1 < best) best = left_p1;
      if (diag_c < best) best = diag_c;
   end
   assign row_we    = cmd.init_step || cmd.cell_write;
   assign row_wdata = cmd.init_step ? j_ff : best;

   always_ff @(posedge clock) begin
      if (row_we) row_mem[j_ff] <= row_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.cell_read) row_rd_ff <= row_mem[j_ff];
   end

   // counts and truncation
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_cnt_ff <= '0;
         qry_cnt_ff <= '0;
         trunc_ff   <= 1'b0;
         thr_ff     <= THR_RESET;
      end else begin
         if (csr_wr_en) thr_ff <= csr_wr_data;
         if (cmd.finish) begin
            ref_cnt_ff <= '0;
            qry_cnt_ff <= '0;
            trunc_ff   <= 1'b0;
         end else if (cmd.load && char_n != '0) begin
            if (req_command == CMD_REF) begin
               if (ref_full) trunc_ff <= 1'b1;
               else ref_cnt_ff <= ref_cnt_ff + 1'b1;
            end else begin
               if (qry_full) trunc_ff <= 1'b1;
               else qry_cnt_ff <= qry_cnt_ff + 1'b1;
            end
         end
      end
   end

   // sweep counters and cell neighbors
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         i_ff <= CNT_W'(1);
         j_ff <= CNT_W'(1);
      end else if (cmd.init_step) begin
         j_ff <= j_ff + 1'b1;
      end else if (cmd.row_start) begin
         j_ff    <= CNT_W'(1);
         left_ff <= i_ff;
         diag_ff <= i_m1;
      end else if (cmd.cell_write) begin
         left_ff <= best;
         diag_ff <= row_rd_ff;
         if (sts.col_last) i_ff <= i_ff + 1'b1;
         else j_ff <= j_ff + 1'b1;
      end
   end

   assign maxlen = (ref_cnt_ff > qry_cnt_ff) ? ref_cnt_ff : qry_cnt_ff;
   assign dist_n = sts.both_nonzero ? left_ff : maxlen;

   // restoring divider, one quotient bit per cycle
   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, res_max_ff});
   assign rem_n  = q_bit ? CNT_W'(rem_sh - {1'b0, res_max_ff}) : rem_sh[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.finish) begin
         div_cnt_ff <= DIV_CNT_W'(NUM_W);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_dist_ff  <= dist_n;
         res_ref_ff   <= ref_cnt_ff;
         res_qry_ff   <= qry_cnt_ff;
         res_max_ff   <= maxlen;
         res_trunc_ff <= trunc_ff;
         num_ff       <= {maxlen - dist_n, FRAC_W'(0)};
         quo_ff       <= {maxlen - dist_n, FRAC_W'(0)};
         rem_ff       <= '0;
         prod_ff      <= PROD_W'(thr_ff) * PROD_W'(maxlen);
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[NUM_W-2:0], q_bit};
         rem_ff <= rem_n;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_distance     <= res_dist_ff;
         rsp_ref_length   <= res_ref_ff;
         rsp_query_length <= res_qry_ff;
         rsp_overflow     <= res_trunc_ff;
         if (res_max_ff == '0) begin
            rsp_similarity_q16 <= SIM_ONE;
            rsp_is_match       <= (thr_ff <= SIM_ONE);
         end else begin
            rsp_similarity_q16 <= quo_ff[SIM_W-1:0];
            rsp_is_match       <= ({1'b0, num_ff} >= prod_ff);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign sts.trigger      = (req_command == CMD_QUERY) && req_last;
   assign sts.both_nonzero = (ref_cnt_ff != '0) && (qry_cnt_ff != '0);
   assign sts.col_last     = (j_ff == qry_cnt_ff);
   assign sts.row_last     = (i_ff == ref_cnt_ff);
   assign sts.div_done     = (div_cnt_ff == '0);
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

[rtl/core/normalized_edit_distance_similarity.sv]
// ----------------------------------------------------------------------------
// normalized_edit_distance_similarity
// edit distance similarity of a reference and a query name, with match flag
// ----------------------------------------------------------------------------
// Bytes load one per cycle while the block is idle; letters and digits are
// kept (lower case), everything else is dropped, and at most 64 characters
// per name are stored. A query byte with last set starts the computation:
// the distance row memory is swept cell by cell (read, then write), which is
// skipped when either name is empty, then a restoring divider produces one
// similarity bit per cycle. The result sits in an output register, so the
// next name bytes are taken while it waits to be read.
module normalized_edit_distance_similarity
   import neds_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [CODE_W-1:0]   req_char_code,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CNT_W-1:0]    rsp_distance,
   output logic [CNT_W-1:0]    rsp_ref_length,
   output logic [CNT_W-1:0]    rsp_query_length,
   output logic [SIM_W-1:0]    rsp_similarity_q16,
   output logic                rsp_is_match,
   output logic                rsp_overflow,
   input  logic                csr_wr_en,
   input  logic [SIM_W-1:0]    csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   neds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   neds_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_command        (req_command),
      .req_char_code      (req_char_code),
      .req_last           (req_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_distance       (rsp_distance),
      .rsp_ref_length     (rsp_ref_length),
      .rsp_query_length   (rsp_query_length),
      .rsp_similarity_q16 (rsp_similarity_q16),
      .rsp_is_match       (rsp_is_match),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

[rtl/core/neds_checker.sv]
// ----------------------------------------------------------------------------
// neds_checker
// port-level checks on the result channel of the similarity block
// ----------------------------------------------------------------------------
`include "normalized_edit_distance_similarity_macros.svh"

module neds_checker
   import neds_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [CNT_W-1:0]    rsp_distance,
   input logic [CNT_W-1:0]    rsp_ref_length,
   input logic [CNT_W-1:0]    rsp_query_length,
   input logic [SIM_W-1:0]    rsp_similarity_q16
);

   // stalled transaction keeps its distance and similarity
   `NEDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_distance) && $stable(rsp_similarity_q16), "result changed while stalled")

   // distance never exceeds the longer name
   `NEDS_ASSERT(a_dist_bound, clock, reset, !rsp_valid || rsp_distance <= rsp_ref_length || rsp_distance <= rsp_query_length, "distance above longer length")

   // two empty names are identical
   `NEDS_ASSERT(a_both_empty, clock, reset, !(rsp_valid && rsp_ref_length == 0 && rsp_query_length == 0) || (rsp_distance == 0 && rsp_similarity_q16 == SIM_ONE), "empty names not identical")

   // one empty name gives zero similarity
   `NEDS_ASSERT(a_one_empty, clock, reset, !(rsp_valid && ((rsp_ref_length == 0) != (rsp_query_length == 0))) || rsp_similarity_q16 == 0, "one empty name not zero similarity")

endmodule

bind normalized_edit_distance_similarity neds_checker u_neds_checker (.*);
